// ===== sv/assert_macros.svh =====
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset
`define FPFA_ASSERT(lbl, clk_i, rstn_i, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
        else $error("fpfa assertion failed");
// Condition in one cycle implies a condition in the next
`define FPFA_ASSERT_NEXT(lbl, clk_i, rstn_i, cond, prop) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond) |=> (prop)) \
        else $error("fpfa assertion failed");
`else
`define FPFA_ASSERT(lbl, clk_i, rstn_i, prop)
`define FPFA_ASSERT_NEXT(lbl, clk_i, rstn_i, cond, prop)
`endif

`endif

// ===== sv/fpfa_pkg.sv =====
// Package: field widths, codes and control structs of the partition allocator
`timescale 1ns / 1ps

package fpfa_pkg;

    // Default table geometry
    localparam int ENTRIES_DEF   = 16;
    localparam int SIZE_BITS_DEF = 16;

    // Item field widths
    localparam int FUNC_W       = 1;
    localparam int IDX_FIELD_W  = 4;
    localparam int SIZE_FIELD_W = 16;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

    // Placement policy codes
    localparam int POL_W = 2;
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Configuration port
    localparam int CNT_FIELD_W = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_IDX_W-1:0]   CFG_POLICY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]   CFG_ACTIVE   = 1'b1;
    localparam logic [CNT_FIELD_W-1:0] ACTIVE_RESET = 5'd16;

    // Table write controls
    typedef struct packed {
        logic we;       // write this entry
        logic size_we;  // also write the size
        logic free;     // new free mark
    } tbl_ctl_t;

    // Scan status back to the sequencer
    typedef struct packed {
        logic done;     // scan finished this cycle
        logic found;    // a qualifying entry was chosen
    } scan_stat_t;

endpackage

// ===== sv/fpfa_table.sv =====
// Partition table: size memory and free marks, one write and one registered read port
`timescale 1ns / 1ps

module fpfa_table #(
    parameter int ENTRIES   = fpfa_pkg::ENTRIES_DEF,
    parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fpfa_pkg::tbl_ctl_t          wr,
    input  logic [$clog2(ENTRIES)-1:0]  wr_addr,
    input  logic [SIZE_BITS-1:0]        wr_size,
    input  logic                        rd_en,
    input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
    output logic [SIZE_BITS-1:0]        rd_size,
    output logic                        rd_free
);
    import fpfa_pkg::*;

    logic [SIZE_BITS-1:0] size_mem_reg [ENTRIES];
    logic [SIZE_BITS-1:0] rd_size_reg;
    logic [ENTRIES-1:0]   free_reg;
    logic                 rd_free_reg;

    // Size memory, no reset: only loaded entries can be free
    always_ff @(posedge clk)
    begin
        if (wr.we && wr.size_we)
        begin
            size_mem_reg[wr_addr] <= wr_size;
        end
        if (rd_en)
        begin
            rd_size_reg <= size_mem_reg[rd_addr];
        end
    end

    // Free marks: all taken after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg    <= '0;
            rd_free_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                free_reg[wr_addr] <= wr.free;
            end
            if (rd_en)
            begin
                rd_free_reg <= free_reg[rd_addr];
            end
        end
    end

    assign rd_size = rd_size_reg;
    assign rd_free = rd_free_reg;

endmodule

// ===== sv/fpfa_cmp.sv =====
// Shared compare unit: does the entry under test fit, and does it beat the current pick
`timescale 1ns / 1ps

module fpfa_cmp #(
    parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
    input  logic [fpfa_pkg::POL_W-1:0]        policy,
    input  logic [fpfa_pkg::SIZE_FIELD_W-1:0] need,
    input  logic                              free,
    input  logic [SIZE_BITS-1:0]              size,
    input  logic                              have,
    input  logic [SIZE_BITS-1:0]              best_size,
    output logic                              take
);
    import fpfa_pkg::*;

    localparam int CMP_W = (SIZE_BITS > SIZE_FIELD_W) ? SIZE_BITS : SIZE_FIELD_W;

    logic fits;
    logic better;

    // Qualify: free and large enough
    assign fits = free && (CMP_W'(size) >= CMP_W'(need));

    // Replace the pick only under best or worst fit; ties keep the lower index
    always_comb
    begin
        case (policy)
            POL_BEST:  better = (size < best_size);
            POL_WORST: better = (size > best_size);
            default:   better = 1'b0;
        endcase
    end

    assign take = fits && (!have || better);

endmodule

// ===== sv/fpfa_scan.sv =====
// Scan sequencer: walks the active entries one per cycle through the compare unit
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fpfa_scan #(
    parameter int ENTRIES   = fpfa_pkg::ENTRIES_DEF,
    parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [$clog2(ENTRIES+1)-1:0]      limit,
    input  logic [fpfa_pkg::POL_W-1:0]        policy,
    input  logic [fpfa_pkg::SIZE_FIELD_W-1:0] need,
    output logic                              rd_en,
    output logic [$clog2(ENTRIES)-1:0]        rd_addr,
    input  logic [SIZE_BITS-1:0]              rd_size,
    input  logic                              rd_free,
    output fpfa_pkg::scan_stat_t              stat,
    output logic [$clog2(ENTRIES)-1:0]        best_idx,
    output logic [SIZE_BITS-1:0]              best_size
);
    import fpfa_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic [CNT_W-1:0]     cnt_reg;
    logic                 run_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic                 have_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [SIZE_BITS-1:0] best_size_reg;
    logic                 issue;
    logic                 take;

    // Read issue and end of scan
    assign issue     = run_reg && (cnt_reg < limit);
    assign rd_en     = issue;
    assign rd_addr   = cnt_reg[IDX_W-1:0];
    assign stat.done = run_reg && !(cnt_reg < limit) && !pend_reg;
    assign stat.found = have_reg;
    assign best_idx  = best_idx_reg;
    assign best_size = best_size_reg;

    fpfa_cmp #(
        .SIZE_BITS (SIZE_BITS)
    ) u_cmp (
        .policy    (policy),
        .need      (need),
        .free      (rd_free),
        .size      (rd_size),
        .have      (have_reg),
        .best_size (best_size_reg),
        .take      (take)
    );

    // Control: counter, read pipeline flag, pick flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            pend_reg <= 1'b0;
            have_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b1;
            pend_reg <= 1'b0;
            have_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (issue)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (pend_reg && take)
            begin
                have_reg <= 1'b1;
            end
            if (stat.done)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    // Payload: index in flight and the current pick
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pend_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (!start && pend_reg && take)
        begin
            best_idx_reg  <= pend_idx_reg;
            best_size_reg <= rd_size;
        end
    end

    // A scan never ends with a read still in flight
    `FPFA_ASSERT(a_done_drained, clk, rst_n, stat.done |-> !pend_reg)
    // A read in flight only belongs to a running scan
    `FPFA_ASSERT(a_pend_in_run, clk, rst_n, pend_reg |-> run_reg)
    // The pick always lies inside the searched range
    `FPFA_ASSERT(a_pick_in_range, clk, rst_n, (run_reg && have_reg) |-> (32'(best_idx_reg) < 32'(limit)))

endmodule

// ===== sv/fixed_partition_fit_allocator.sv =====
// Top level: fixed-partition fit allocator with sequencer, configuration and output register
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------------
//  in       | in_valid / in_stall  | func, entry_index, entry_size, entry_free, req_size
//  out      | out_valid / out_stall| granted, part_index, part_size
//  cfg      | cfg_we               | cfg_index, cfg_data
//
// A load item passes through the write and finish states before its result enters the output register.
// An allocate item scans L = min(active_count, ENTRIES) entries, then commits and finishes;
// the scan reads one entry a cycle through the single read port and one compare unit.
// One item is in the block at a time; in_stall is low only while the sequencer is idle.
// While a result waits in the output register under out_stall, the next item is still
// accepted and processed, then holds in the finish state with in_stall high until it frees.
// After reset every partition is marked taken; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_partition_fit_allocator #(
    parameter int ENTRIES   = fpfa_pkg::ENTRIES_DEF,
    parameter int SIZE_BITS = fpfa_pkg::SIZE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fpfa_pkg::FUNC_W-1:0]         func,
    input  logic [fpfa_pkg::IDX_FIELD_W-1:0]    entry_index,
    input  logic [fpfa_pkg::SIZE_FIELD_W-1:0]   entry_size,
    input  logic                                entry_free,
    input  logic [fpfa_pkg::SIZE_FIELD_W-1:0]   req_size,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                granted,
    output logic [fpfa_pkg::IDX_FIELD_W-1:0]    part_index,
    output logic [fpfa_pkg::SIZE_FIELD_W-1:0]   part_size,
    input  logic                                cfg_we,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fpfa_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fpfa_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [POL_W-1:0]         policy_reg;
    logic [CNT_FIELD_W-1:0]   active_reg;
    logic [IDX_FIELD_W-1:0]   idx_reg;
    logic [SIZE_FIELD_W-1:0]  esize_reg;
    logic                     efree_reg;
    logic [SIZE_FIELD_W-1:0]  job_reg;
    logic                     res_granted_reg;
    logic [IDX_FIELD_W-1:0]   res_index_reg;
    logic [SIZE_FIELD_W-1:0]  res_size_reg;
    logic                     out_valid_reg;
    logic                     granted_reg;
    logic [IDX_FIELD_W-1:0]   part_index_reg;
    logic [SIZE_FIELD_W-1:0]  part_size_reg;

    logic                     accept;
    logic                     out_load;
    logic                     scan_start;
    logic [CNT_W-1:0]         limit;
    logic                     load_in_range;
    tbl_ctl_t                 tbl_ctl;
    logic [IDX_W-1:0]         tbl_wr_addr;
    logic [SIZE_BITS-1:0]     tbl_wr_size;
    logic                     scan_rd_en;
    logic [IDX_W-1:0]         scan_rd_addr;
    logic [SIZE_BITS-1:0]     tbl_rd_size;
    logic                     tbl_rd_free;
    scan_stat_t               stat;
    logic [IDX_W-1:0]         best_idx;
    logic [SIZE_BITS-1:0]     best_size;

    // Handshakes
    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign out_load   = !out_valid_reg || !out_stall;
    assign scan_start = accept && (func == FUNC_ALLOC);
    assign out_valid  = out_valid_reg;
    assign granted    = granted_reg;
    assign part_index = part_index_reg;
    assign part_size  = part_size_reg;

    // Search limit, clipped to the table depth
    assign limit = (32'(active_reg) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(active_reg);
    assign load_in_range = (32'(idx_reg) < ENTRIES);

    // Table write: loads, and clearing the free mark of a granted entry
    always_comb
    begin
        tbl_ctl     = '0;
        tbl_wr_addr = IDX_W'(idx_reg);
        tbl_wr_size = SIZE_BITS'(esize_reg);
        case (state_reg)
            ST_WRITE:
            begin
                tbl_ctl.we      = load_in_range;
                tbl_ctl.size_we = 1'b1;
                tbl_ctl.free    = efree_reg;
            end
            ST_COMMIT:
            begin
                tbl_ctl.we  = stat.found;
                tbl_wr_addr = best_idx;
            end
            default:
            begin
                tbl_ctl = '0;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLICY: policy_reg <= cfg_data[POL_W-1:0];
                CFG_ACTIVE: active_reg <= cfg_data[CNT_FIELD_W-1:0];
                default:    ;
            endcase
        end
    end

    fpfa_table #(
        .ENTRIES   (ENTRIES),
        .SIZE_BITS (SIZE_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (tbl_ctl),
        .wr_addr (tbl_wr_addr),
        .wr_size (tbl_wr_size),
        .rd_en   (scan_rd_en),
        .rd_addr (scan_rd_addr),
        .rd_size (tbl_rd_size),
        .rd_free (tbl_rd_free)
    );

    fpfa_scan #(
        .ENTRIES   (ENTRIES),
        .SIZE_BITS (SIZE_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .limit     (limit),
        .policy    (policy_reg),
        .need      (job_reg),
        .rd_en     (scan_rd_en),
        .rd_addr   (scan_rd_addr),
        .rd_size   (tbl_rd_size),
        .rd_free   (tbl_rd_free),
        .stat      (stat),
        .best_idx  (best_idx),
        .best_size (best_size)
    );

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            esize_reg       <= '0;
            efree_reg       <= 1'b0;
            job_reg         <= '0;
            res_granted_reg <= 1'b0;
            res_index_reg   <= '0;
            res_size_reg    <= '0;
            out_valid_reg   <= 1'b0;
            granted_reg     <= 1'b0;
            part_index_reg  <= '0;
            part_size_reg   <= '0;
        end
        else
        begin
            // Output register empties when taken; a finishing item refills it below
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg   <= entry_index;
                        esize_reg <= entry_size;
                        efree_reg <= entry_free;
                        job_reg   <= req_size;
                        state_reg <= (func == FUNC_ALLOC) ? ST_SCAN : ST_WRITE;
                    end
                end
                ST_WRITE:
                begin
                    // load acknowledge carries all zeros
                    res_granted_reg <= 1'b0;
                    res_index_reg   <= '0;
                    res_size_reg    <= '0;
                    state_reg       <= ST_FINISH;
                end
                ST_SCAN:
                begin
                    if (stat.done)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT:
                begin
                    res_granted_reg <= stat.found;
                    res_index_reg   <= stat.found ? IDX_FIELD_W'(best_idx) : '0;
                    res_size_reg    <= stat.found ? SIZE_FIELD_W'(best_size) : '0;
                    state_reg       <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        out_valid_reg  <= 1'b1;
                        granted_reg    <= res_granted_reg;
                        part_index_reg <= res_index_reg;
                        part_size_reg  <= res_size_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A result without a grant reports zero index and size
    `FPFA_ASSERT(a_nogrant_zero, clk, rst_n, (out_valid_reg && !granted_reg) |-> (part_index_reg == '0 && part_size_reg == '0))
    // A finished item reaches the output exactly when the register frees
    `FPFA_ASSERT_NEXT(a_finish_emits, clk, rst_n, (state_reg == ST_FINISH && out_load), (out_valid_reg && state_reg == ST_IDLE))
    // Table reads and writes never share a cycle
    `FPFA_ASSERT(a_no_rw_clash, clk, rst_n, !(scan_rd_en && tbl_ctl.we))

endmodule
